// ----- rtl/shallow_water_cell_update_core_defines.svh -----
// assertion macros for the shallow-water cell update core
// used by the top level only, no other dependencies
`ifndef SHALLOW_WATER_CELL_UPDATE_CORE_DEFINES_SVH
`define SHALLOW_WATER_CELL_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SWCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SWCU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/swcu_pkg.sv -----
// shared types, constants and helpers of the shallow-water cell update core
// no dependencies
package swcu_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int HEIGHT_WIDTH   = 31;
   localparam int VEL_WIDTH      = 32;
   localparam int DAMP_WIDTH     = 17;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int NUM_STAGES     = 9;

   // register reset values
   localparam logic [30:0] TIME_STEP_RESET   = 31'd655;
   localparam logic [30:0] GRAVITY_RESET     = 31'd642908;
   localparam logic [30:0] INV_SPACING_RESET = 31'd16384;
   localparam logic [16:0] DAMPING_RESET     = 17'd65470;
   localparam logic [30:0] MIN_HEIGHT_RESET  = 31'd655;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_GRAVITY     = 3'd1,
      CSR_INV_SPACING = 3'd2,
      CSR_DAMPING     = 3'd3,
      CSR_MIN_HEIGHT  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        [HEIGHT_WIDTH-1:0] center_height;
      logic signed [VEL_WIDTH-1:0]    center_vel_x;
      logic signed [VEL_WIDTH-1:0]    center_vel_y;
      logic        [HEIGHT_WIDTH-1:0] east_height;
      logic        [HEIGHT_WIDTH-1:0] west_height;
      logic signed [VEL_WIDTH-1:0]    east_vel_x;
      logic signed [VEL_WIDTH-1:0]    west_vel_x;
      logic        [HEIGHT_WIDTH-1:0] north_height;
      logic        [HEIGHT_WIDTH-1:0] south_height;
      logic signed [VEL_WIDTH-1:0]    north_vel_y;
      logic signed [VEL_WIDTH-1:0]    south_vel_y;
      logic                           is_border;
   } req_type;

   typedef struct packed {
      logic        [HEIGHT_WIDTH-1:0] new_height;
      logic signed [VEL_WIDTH-1:0]    new_vel_x;
      logic signed [VEL_WIDTH-1:0]    new_vel_y;
   } rsp_type;

   // cell values carried alongside the arithmetic for the border bypass
   typedef struct packed {
      logic                           border;
      logic        [HEIGHT_WIDTH-1:0] h;
      logic signed [VEL_WIDTH-1:0]    u;
      logic signed [VEL_WIDTH-1:0]    v;
   } cell_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (x < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/shallow_water_cell_update_core.sv -----
// Shallow-water cell update core.
// Throughput one request per clock while rsp_stall is low; each of the nine stages holds one cell and a
// stage refills as soon as its content moves on, so bubbles close up under rsp_stall.
// The depth is set by the chain of three dependent multiplies (difference scaling,
// momentum/continuity terms, time step) plus damping, each followed by a register.
// Synchronous active-high reset empties the pipeline and loads the register defaults.
module shallow_water_cell_update_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  swcu_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output swcu_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [swcu_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [swcu_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import swcu_pkg::*;
   `include "shallow_water_cell_update_core_defines.svh"

   // configuration registers
   logic [30:0] time_step_ff;
   logic [30:0] gravity_ff;
   logic [30:0] inv_spacing_ff;
   logic [16:0] damping_ff;
   logic [30:0] min_height_ff;

   // pipeline control
   logic [NUM_STAGES:1] valid_ff;
   logic [NUM_STAGES:1] valid_up;
   logic [NUM_STAGES:1] stage_load;
   cell_type            cell_ff [1:NUM_STAGES-1];
   cell_type            cell_in;

   // stage 1: differences
   logic signed [32:0] d_hx_ff, d_hy_ff, d_ux_ff, d_vy_ff;
   logic signed [32:0] d_hx_in, d_hy_in, d_ux_in, d_vy_in;
   // stage 2: scaled difference products and dt*h
   logic signed [64:0] p_hx_ff, p_hy_ff, p_ux_ff, p_vy_ff;
   logic signed [64:0] p_hx_in, p_hy_in, p_ux_in, p_vy_in;
   logic signed [63:0] p_dth_ff, p_dth_in;
   // stage 3: gradients
   logic signed [31:0] dhdx_ff, dhdy_ff, dudx_ff, dvdy_ff, dth_ff;
   logic signed [31:0] dhdx_in, dhdy_in, dudx_in, dvdy_in, dth_in;
   // stage 4: divergence and momentum products
   logic signed [31:0] div_ff, div_in, dth4_ff;
   logic signed [63:0] p_gx_ff, p_ux2_ff, p_gy_ff, p_vy2_ff;
   logic signed [63:0] p_gx_in, p_ux2_in, p_gy_in, p_vy2_in;
   // stage 5: accelerations and height change product
   logic signed [31:0] ax_ff, ay_ff, ax_in, ay_in;
   logic signed [63:0] p_div_ff, p_div_in;
   // stage 6: new height and time-step products
   logic [30:0]        nh_ff, nh_in;
   logic signed [63:0] p_tx_ff, p_ty_ff, p_tx_in, p_ty_in;
   // stage 7: updated velocities
   logic [30:0]        nh7_ff;
   logic signed [31:0] nu_ff, nv_ff, nu_in, nv_in;
   // stage 8: damping products
   logic [30:0]        nh8_ff;
   logic signed [49:0] p_du_ff, p_dv_ff, p_du_in, p_dv_in;
   // stage 9: output register
   rsp_type            rsp_ff, rsp_in;

   // scratch values
   logic signed [31:0] ids_s, dt_s, g_s;
   logic signed [64:0] sh_hx, sh_hy, sh_ux, sh_vy;
   logic signed [63:0] sh_dth, sh_gx, sh_ux2, sh_gy, sh_vy2, sh_div, sh_tx, sh_ty;
   logic signed [63:0] nh_wide;
   logic signed [49:0] sh_du, sh_dv;

   assign ids_s = $signed({1'b0, inv_spacing_ff});
   assign dt_s  = $signed({1'b0, time_step_ff});
   assign g_s   = $signed({1'b0, gravity_ff});

   // configuration writes, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff   <= TIME_STEP_RESET;
         gravity_ff     <= GRAVITY_RESET;
         inv_spacing_ff <= INV_SPACING_RESET;
         damping_ff     <= DAMPING_RESET;
         min_height_ff  <= MIN_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_TIME_STEP:   time_step_ff   <= csr_data[30:0];
            CSR_GRAVITY:     gravity_ff     <= csr_data[30:0];
            CSR_INV_SPACING: inv_spacing_ff <= csr_data[30:0];
            CSR_DAMPING:     damping_ff     <= csr_data[16:0];
            CSR_MIN_HEIGHT:  min_height_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // stage load enables: a stage loads when empty or when its content moves on
   always_comb begin
      stage_load[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
   end

   assign req_stall = !stage_load[1];
   assign valid_up  = {valid_ff[NUM_STAGES-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (stage_load[k]) begin
               valid_ff[k] <= valid_up[k];
            end
         end
      end
   end

   // cell bypass values travel with the item
   assign cell_in = '{border: req_data.is_border, h: req_data.center_height,
                      u: req_data.center_vel_x, v: req_data.center_vel_y};

   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         cell_ff[1] <= cell_in;
      end
      for (int k = 2; k <= NUM_STAGES - 1; k++) begin
         if (stage_load[k]) begin
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   // stage 1: central differences, y taken south minus north
   always_comb begin
      d_hx_in = $signed({2'b00, req_data.east_height}) - $signed({2'b00, req_data.west_height});
      d_hy_in = $signed({2'b00, req_data.south_height}) - $signed({2'b00, req_data.north_height});
      d_ux_in = $signed({req_data.east_vel_x[31], req_data.east_vel_x})
              - $signed({req_data.west_vel_x[31], req_data.west_vel_x});
      d_vy_in = $signed({req_data.south_vel_y[31], req_data.south_vel_y})
              - $signed({req_data.north_vel_y[31], req_data.north_vel_y});
   end

   // stage 2: scale by reciprocal spacing, dt times height
   always_comb begin
      p_hx_in  = d_hx_ff * ids_s;
      p_hy_in  = d_hy_ff * ids_s;
      p_ux_in  = d_ux_ff * ids_s;
      p_vy_in  = d_vy_ff * ids_s;
      p_dth_in = dt_s * $signed({1'b0, cell_ff[1].h});
   end

   // stage 3: floor shift and saturate
   always_comb begin
      sh_hx   = p_hx_ff >>> FRAC_BITS;
      sh_hy   = p_hy_ff >>> FRAC_BITS;
      sh_ux   = p_ux_ff >>> FRAC_BITS;
      sh_vy   = p_vy_ff >>> FRAC_BITS;
      sh_dth  = p_dth_ff >>> FRAC_BITS;
      dhdx_in = sat32(sh_hx[63:0]);
      dhdy_in = sat32(sh_hy[63:0]);
      dudx_in = sat32(sh_ux[63:0]);
      dvdy_in = sat32(sh_vy[63:0]);
      dth_in  = sat32(sh_dth);
   end

   // stage 4: divergence, gravity and advection products
   always_comb begin
      div_in   = sat32(64'(dudx_ff) + 64'(dvdy_ff));
      p_gx_in  = g_s * dhdx_ff;
      p_gy_in  = g_s * dhdy_ff;
      p_ux2_in = cell_ff[3].u * dudx_ff;
      p_vy2_in = cell_ff[3].v * dvdy_ff;
   end

   // stage 5: accelerations, height change product
   always_comb begin
      sh_gx    = p_gx_ff >>> FRAC_BITS;
      sh_ux2   = p_ux2_ff >>> FRAC_BITS;
      sh_gy    = p_gy_ff >>> FRAC_BITS;
      sh_vy2   = p_vy2_ff >>> FRAC_BITS;
      ax_in    = sat32(64'(sat32(sh_gx)) + 64'(sat32(sh_ux2)));
      ay_in    = sat32(64'(sat32(sh_gy)) + 64'(sat32(sh_vy2)));
      p_div_in = dth4_ff * div_ff;
   end

   // stage 6: continuity update clamped between min height and the 31-bit maximum, time-step products
   always_comb begin
      sh_div  = p_div_ff >>> FRAC_BITS;
      nh_wide = 64'($signed({1'b0, cell_ff[5].h})) - sh_div;
      if (nh_wide < 64'($signed({1'b0, min_height_ff}))) begin
         nh_in = min_height_ff;
      end else if (nh_wide > S32_MAX) begin
         nh_in = 31'h7fffffff;
      end else begin
         nh_in = nh_wide[30:0];
      end
      p_tx_in = dt_s * ax_ff;
      p_ty_in = dt_s * ay_ff;
   end

   // stage 7: momentum update
   always_comb begin
      sh_tx = p_tx_ff >>> FRAC_BITS;
      sh_ty = p_ty_ff >>> FRAC_BITS;
      nu_in = sat32(64'(cell_ff[6].u) - sh_tx);
      nv_in = sat32(64'(cell_ff[6].v) - sh_ty);
   end

   // stage 8: damping products
   always_comb begin
      p_du_in = nu_ff * $signed({1'b0, damping_ff});
      p_dv_in = nv_ff * $signed({1'b0, damping_ff});
   end

   // stage 9: final saturation and border bypass
   always_comb begin
      sh_du = p_du_ff >>> FRAC_BITS;
      sh_dv = p_dv_ff >>> FRAC_BITS;
      if (cell_ff[8].border) begin
         rsp_in.new_height = cell_ff[8].h;
         rsp_in.new_vel_x  = cell_ff[8].u;
         rsp_in.new_vel_y  = cell_ff[8].v;
      end else begin
         rsp_in.new_height = nh8_ff;
         rsp_in.new_vel_x  = sat32(64'(sh_du));
         rsp_in.new_vel_y  = sat32(64'(sh_dv));
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (stage_load[1]) begin
         d_hx_ff <= d_hx_in;
         d_hy_ff <= d_hy_in;
         d_ux_ff <= d_ux_in;
         d_vy_ff <= d_vy_in;
      end
      if (stage_load[2]) begin
         p_hx_ff  <= p_hx_in;
         p_hy_ff  <= p_hy_in;
         p_ux_ff  <= p_ux_in;
         p_vy_ff  <= p_vy_in;
         p_dth_ff <= p_dth_in;
      end
      if (stage_load[3]) begin
         dhdx_ff <= dhdx_in;
         dhdy_ff <= dhdy_in;
         dudx_ff <= dudx_in;
         dvdy_ff <= dvdy_in;
         dth_ff  <= dth_in;
      end
      if (stage_load[4]) begin
         div_ff   <= div_in;
         dth4_ff  <= dth_ff;
         p_gx_ff  <= p_gx_in;
         p_gy_ff  <= p_gy_in;
         p_ux2_ff <= p_ux2_in;
         p_vy2_ff <= p_vy2_in;
      end
      if (stage_load[5]) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         p_div_ff <= p_div_in;
      end
      if (stage_load[6]) begin
         nh_ff   <= nh_in;
         p_tx_ff <= p_tx_in;
         p_ty_ff <= p_ty_in;
      end
      if (stage_load[7]) begin
         nh7_ff <= nh_ff;
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
      end
      if (stage_load[8]) begin
         nh8_ff  <= nh7_ff;
         p_du_ff <= p_du_in;
         p_dv_ff <= p_dv_in;
      end
      if (stage_load[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[NUM_STAGES];
   assign rsp_data  = rsp_ff;

   // checks
   `SWCU_ASSERT_NEXT(a_accept_fills_stage1, clock, reset, req_valid && !req_stall, valid_ff[1], "accepted request did not reach stage 1")
   `SWCU_ASSERT_NOW(a_full_pipe_blocks, clock, reset, (&valid_ff) && rsp_stall, req_stall, "full stalled pipeline took a request")
   `SWCU_ASSERT_NEXT(a_bad_index_ignored, clock, reset, csr_valid && (csr_index > CSR_MIN_HEIGHT), $stable({time_step_ff, gravity_ff, inv_spacing_ff, damping_ff, min_height_ff}), "write to unknown register changed configuration")

endmodule
